/* rtl/tmfp_pkg.sv */
// shared types and constants of the morph file parser
// record kinds, status codes, queue record and push request structs
// no dependencies
package tmfp_pkg;

  typedef enum logic [2:0] {
    KindShapeLen  = 3'd0,
    KindShapeChar = 3'd1,
    KindMorphHdr  = 3'd2,
    KindMorphChar = 3'd3,
    KindDelta     = 3'd4,
    KindStatus    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadMagic = 2'd1,
    StatusTrunc    = 2'd2,
    StatusTrailing = 2'd3
  } status_e;

  localparam int unsigned QDepth = 4;

  // one result on its way from the parser to the arithmetic back end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  col;
    logic [15:0] mv;
    logic [15:0] vn;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    logic [31:0] mult;
    status_e     st;
    logic        run_end;
  } rec_t;

  // up to two records pushed per accepted byte
  typedef struct packed {
    logic we0;
    logic we1;
    rec_t r0;
    rec_t r1;
  } push_t;

  function automatic logic [7:0] magic_byte(logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h50;
      2'd1:    b = 8'h49;
      2'd2:    b = 8'h52;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

/* rtl/tmfp_front.sv */
// parser front end: walks the file byte by byte and builds records
// depends on tmfp_pkg
module tmfp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      byte_i,
  input  logic            final_i,
  output tmfp_pkg::push_t push_o
);

  localparam logic [3:0] PhMagic     = 4'd0;
  localparam logic [3:0] PhShapeCnt  = 4'd1;
  localparam logic [3:0] PhShapeLen  = 4'd2;
  localparam logic [3:0] PhShapeName = 4'd3;
  localparam logic [3:0] PhMorphCnt  = 4'd4;
  localparam logic [3:0] PhMorphLen  = 4'd5;
  localparam logic [3:0] PhMorphName = 4'd6;
  localparam logic [3:0] PhMult      = 4'd7;
  localparam logic [3:0] PhVcount    = 4'd8;
  localparam logic [3:0] PhVertex    = 4'd9;
  localparam logic [3:0] PhSkip      = 4'd10;
  localparam logic [3:0] PhDone      = 4'd11;

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] asm_q, asm_d;
  logic        uv_q, uv_d;
  logic [15:0] shapes_q, shapes_d;
  logic        first_q, first_d;
  logic [15:0] morphs_q, morphs_d;
  logic [15:0] verts_q, verts_d;
  logic [7:0]  name_q, name_d;
  logic [19:0] skip_q, skip_d;
  logic [31:0] mult_q, mult_d;
  logic [15:0] hidx_q, hidx_d;
  logic [15:0] hdx_q, hdx_d;
  logic [15:0] hdy_q, hdy_d;
  logic [1:0]  err_q, err_d;

  logic             emit;
  logic [31:0]      asm_take;
  logic             go_morph, go_shape;
  logic             c_we;
  tmfp_pkg::rec_t   c_rec, s_rec;
  tmfp_pkg::status_e st;
  logic [15:0]      vc;

  // little-endian field assembly
  always_comb begin
    if (cnt_q == 3'd0) begin
      asm_take = {24'b0, byte_i};
    end else begin
      asm_take = asm_q | ({24'b0, byte_i} << {cnt_q[1:0], 3'b000});
    end
  end

  // parse step
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    asm_d    = asm_q;
    uv_d     = uv_q;
    shapes_d = shapes_q;
    first_d  = first_q;
    morphs_d = morphs_q;
    verts_d  = verts_q;
    name_d   = name_q;
    skip_d   = skip_q;
    mult_d   = mult_q;
    hidx_d   = hidx_q;
    hdx_d    = hdx_q;
    hdy_d    = hdy_q;
    err_d    = err_q;
    go_morph = 1'b0;
    go_shape = 1'b0;
    c_we     = 1'b0;
    c_rec    = '0;
    vc       = asm_take[15:0];
    emit     = first_q && !uv_q;

    if (err_q == 2'd0) begin
      unique case (phase_q)
        PhMagic: begin
          if (byte_i != tmfp_pkg::magic_byte(cnt_q[1:0])) begin
            err_d = tmfp_pkg::StatusBadMagic;
          end else if (cnt_q == 3'd3) begin
            cnt_d   = 3'd0;
            phase_d = PhShapeCnt;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhShapeCnt: begin
          asm_d = asm_take;
          if (cnt_q >= 3'd1) begin
            cnt_d    = 3'd0;
            shapes_d = asm_take[15:0];
            go_shape = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhShapeLen: begin
          if (emit) begin
            c_we      = 1'b1;
            c_rec.kind = tmfp_pkg::KindShapeLen;
            c_rec.col = byte_i;
          end
          name_d  = byte_i;
          phase_d = (byte_i != 8'd0) ? PhShapeName : PhMorphCnt;
        end
        PhShapeName: begin
          if (emit) begin
            c_we      = 1'b1;
            c_rec.kind = tmfp_pkg::KindShapeChar;
            c_rec.col = byte_i;
          end
          name_d = name_q - 8'd1;
          if (name_q == 8'd1) phase_d = PhMorphCnt;
        end
        PhMorphCnt: begin
          asm_d = asm_take;
          if (cnt_q >= 3'd1) begin
            cnt_d    = 3'd0;
            morphs_d = asm_take[15:0];
            go_morph = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhMorphLen: begin
          hidx_d  = {8'b0, byte_i};
          name_d  = byte_i;
          phase_d = (byte_i != 8'd0) ? PhMorphName : PhMult;
        end
        PhMorphName: begin
          if (emit) begin
            c_we      = 1'b1;
            c_rec.kind = tmfp_pkg::KindMorphChar;
            c_rec.col = byte_i;
          end
          name_d = name_q - 8'd1;
          if (name_q == 8'd1) phase_d = PhMult;
        end
        PhMult: begin
          asm_d = asm_take;
          if (cnt_q >= 3'd3) begin
            cnt_d   = 3'd0;
            mult_d  = asm_take;
            phase_d = PhVcount;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhVcount: begin
          asm_d = asm_take;
          if (cnt_q >= 3'd1) begin
            cnt_d = 3'd0;
            if (emit) begin
              c_we      = 1'b1;
              c_rec.kind = tmfp_pkg::KindMorphHdr;
              c_rec.col = hidx_q[7:0];
              c_rec.mv  = vc;
              verts_d   = vc;
              if (vc == 16'd0) go_morph = 1'b1;
              else phase_d = PhVertex;
            end else begin
              if (uv_q) skip_d = {2'b0, vc, 2'b0} + {3'b0, vc, 1'b0};
              else      skip_d = {1'b0, vc, 3'b0};
              if (vc == 16'd0) go_morph = 1'b1;
              else phase_d = PhSkip;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhVertex: begin
          if (!cnt_q[0]) asm_d = {24'b0, byte_i};
          else           asm_d = {16'b0, byte_i, asm_q[7:0]};
          if (cnt_q == 3'd1) hidx_d = asm_d[15:0];
          if (cnt_q == 3'd3) hdx_d = asm_d[15:0];
          if (cnt_q == 3'd5) hdy_d = asm_d[15:0];
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            c_we       = 1'b1;
            c_rec.kind = tmfp_pkg::KindDelta;
            c_rec.vn   = hidx_q;
            c_rec.dx   = hdx_q;
            c_rec.dy   = hdy_q;
            c_rec.dz   = asm_d[15:0];
            c_rec.mult = mult_q;
            verts_d    = verts_q - 16'd1;
            if (verts_q == 16'd1) go_morph = 1'b1;
          end
        end
        PhSkip: begin
          skip_d = skip_q - 20'd1;
          if (skip_q == 20'd1) go_morph = 1'b1;
        end
        default: begin
          err_d = tmfp_pkg::StatusTrailing;
        end
      endcase

      // advance to the next morph, or to the next shape
      if (go_morph) begin
        if (morphs_d == 16'd0) begin
          first_d  = 1'b0;
          go_shape = 1'b1;
        end else begin
          morphs_d = morphs_d - 16'd1;
          phase_d  = PhMorphLen;
        end
      end
      if (go_shape) begin
        if (shapes_d == 16'd0) begin
          first_d = 1'b0;
          if (!uv_q) begin
            uv_d    = 1'b1;
            phase_d = PhShapeCnt;
          end else begin
            phase_d = PhDone;
          end
        end else begin
          shapes_d = shapes_d - 16'd1;
          phase_d  = PhShapeLen;
        end
      end
    end

    // status on the final byte
    if (err_d != 2'd0)          st = tmfp_pkg::status_e'(err_d);
    else if (phase_d != PhDone) st = tmfp_pkg::StatusTrunc;
    else                        st = tmfp_pkg::StatusOk;
    s_rec         = '0;
    s_rec.kind    = tmfp_pkg::KindStatus;
    s_rec.st      = st;
    s_rec.run_end = 1'b1;

    push_o = '0;
    if (final_i) begin
      if (c_we) begin
        push_o.we0 = 1'b1;
        push_o.r0  = c_rec;
        push_o.we1 = 1'b1;
        push_o.r1  = s_rec;
      end else begin
        push_o.we0 = 1'b1;
        push_o.r0  = s_rec;
      end
      phase_d  = PhMagic;
      cnt_d    = 3'd0;
      asm_d    = '0;
      uv_d     = 1'b0;
      shapes_d = '0;
      first_d  = 1'b1;
      morphs_d = '0;
      verts_d  = '0;
      name_d   = '0;
      skip_d   = '0;
      mult_d   = '0;
      hidx_d   = '0;
      hdx_d    = '0;
      hdy_d    = '0;
      err_d    = '0;
    end else if (c_we) begin
      push_o.we0        = 1'b1;
      push_o.r0         = c_rec;
      push_o.r0.run_end = 1'b1;
    end
    if (!acc_i) begin
      push_o.we0 = 1'b0;
      push_o.we1 = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMagic;
      cnt_q    <= '0;
      asm_q    <= '0;
      uv_q     <= 1'b0;
      shapes_q <= '0;
      first_q  <= 1'b1;
      morphs_q <= '0;
      verts_q  <= '0;
      name_q   <= '0;
      skip_q   <= '0;
      mult_q   <= '0;
      hidx_q   <= '0;
      hdx_q    <= '0;
      hdy_q    <= '0;
      err_q    <= '0;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      asm_q    <= asm_d;
      uv_q     <= uv_d;
      shapes_q <= shapes_d;
      first_q  <= first_d;
      morphs_q <= morphs_d;
      verts_q  <= verts_d;
      name_q   <= name_d;
      skip_q   <= skip_d;
      mult_q   <= mult_d;
      hidx_q   <= hidx_d;
      hdx_q    <= hdx_d;
      hdy_q    <= hdy_d;
      err_q    <= err_d;
    end
  end

`ifndef SYNTH
  // an error holds until the final byte
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != 2'd0 && acc_i && !final_i) |=> (err_q == $past(err_q)))
    else $error("error code changed before final byte");
  // the final byte restarts the walk
  a_final_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && final_i) |=> (phase_q == PhMagic && err_q == 2'd0 && first_q))
    else $error("state not restored after final byte");
  // a second record is only ever the status
  a_second_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.we1 |-> (push_o.we0 && push_o.r1.kind == tmfp_pkg::KindStatus && final_i))
    else $error("second record is not a status");
`endif

endmodule

/* rtl/tmfp_queue.sv */
// short record queue between parser and back end, two writes and one read a cycle
// depends on tmfp_pkg
module tmfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tmfp_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  output tmfp_pkg::rec_t  rec_o,
  input  logic            pop_i
);

  localparam int unsigned AW = $clog2(tmfp_pkg::QDepth);

  tmfp_pkg::rec_t   mem_q [tmfp_pkg::QDepth];
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic [AW-1:0]    tail_nx;
  logic             do_pop;

  assign tail_nx = tail_q + AW'(1);
  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[head_q];
  assign room_o  = (cnt_q <= (AW+1)'(tmfp_pkg::QDepth - 2));

  // pointers and fill count
  always_comb begin
    tail_d = tail_q;
    if (push_i.we1)      tail_d = tail_q + AW'(2);
    else if (push_i.we0) tail_d = tail_nx;
    head_d = do_pop ? head_q + AW'(1) : head_q;
    cnt_d  = cnt_q + (AW+1)'(push_i.we0) + (AW+1)'(push_i.we1) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.we0) mem_q[tail_q] <= push_i.r0;
    if (push_i.we1) mem_q[tail_nx] <= push_i.r1;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(tmfp_pkg::QDepth))
    else $error("queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.we0 |-> (cnt_q <= (AW+1)'(tmfp_pkg::QDepth - 2)))
    else $error("push without room");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != (AW+1)'(tmfp_pkg::QDepth)) |-> (AW'(cnt_q) == AW'(tail_q - head_q)))
    else $error("pointer and count disagree");
`endif

endmodule

/* rtl/tmfp_fmul.sv */
// one lane: int16 times float32, single rounding to nearest even, three stages
// depends on nothing but the clock enable from the back end
module tmfp_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] raw_i,
  input  logic [31:0] mult_i,
  output logic [31:0] bits_o
);

  // stage one: magnitude product
  logic        s1_sign_q, s1_nan_q, s1_inf_q, s1_vzero_q;
  logic [31:0] s1_m_q;
  logic [7:0]  s1_e_q;
  logic [39:0] s1_p_q;
  logic [15:0] mag;
  logic [23:0] mant;

  assign mag  = raw_i[15] ? (16'd0 - raw_i) : raw_i;
  assign mant = {(mult_i[30:23] != 8'd0), mult_i[22:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q  <= raw_i[15] ^ mult_i[31];
      s1_nan_q   <= (mult_i[30:23] == 8'hFF) && (mult_i[22:0] != 23'd0);
      s1_inf_q   <= (mult_i[30:23] == 8'hFF) && (mult_i[22:0] == 23'd0);
      s1_vzero_q <= (raw_i == 16'd0);
      s1_m_q     <= mult_i;
      s1_e_q     <= (mult_i[30:23] == 8'd0) ? 8'd1 : mult_i[30:23];
      s1_p_q     <= 40'(mag) * 40'(mant);
    end
  end

  // stage two: normalise, denormal shift, guard and sticky
  logic [5:0]  lz;
  logic [39:0] nrm, shd, lost;
  logic [10:0] biased, rsh_w;
  logic        den, ovf;
  logic [4:0]  rsh;
  logic [8:0]  expf;
  logic        s2_sign_q, s2_nan_q, s2_inf_q, s2_vzero_q, s2_pzero_q, s2_ovf_q, s2_inc_q;
  logic [31:0] s2_m_q, s2_base_q;

  always_comb begin
    lz = 6'd40;
    for (int i = 0; i < 40; i++) begin
      if (s1_p_q[i]) lz = 6'(39 - i);
    end
    nrm    = s1_p_q << lz;
    biased = {3'b0, s1_e_q} + 11'd16 - {5'b0, lz};
    den    = biased[10] || (biased == 11'd0);
    ovf    = !biased[10] && (biased >= 11'd255);
    rsh_w  = 11'd1 - biased;
    rsh    = den ? rsh_w[4:0] : 5'd0;
    shd    = nrm >> rsh;
    lost   = nrm & ((40'd1 << rsh) - 40'd1);
    expf   = den ? 9'd0 : 9'(biased - 11'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q  <= s1_sign_q;
      s2_nan_q   <= s1_nan_q;
      s2_inf_q   <= s1_inf_q;
      s2_vzero_q <= s1_vzero_q;
      s2_pzero_q <= (s1_p_q == 40'd0);
      s2_m_q     <= s1_m_q;
      s2_ovf_q   <= ovf;
      s2_base_q  <= {expf[8:0], 23'b0} + {8'b0, shd[39:16]};
      s2_inc_q   <= shd[15] && ((shd[14:0] != 15'd0) || (lost != 40'd0) || shd[16]);
    end
  end

  // stage three: round and pack
  logic [31:0] rnd, res;

  always_comb begin
    rnd = {1'b0, s2_base_q[30:0]} + 32'(s2_inc_q);
    if (s2_nan_q)                      res = s2_m_q | 32'h0040_0000;
    else if (s2_inf_q && s2_vzero_q)   res = 32'hFFC0_0000;
    else if (s2_inf_q)                 res = {s2_sign_q, 8'hFF, 23'd0};
    else if (s2_pzero_q)               res = {s2_sign_q, 31'd0};
    else if (s2_ovf_q || rnd[31:23] >= 9'd255) res = {s2_sign_q, 8'hFF, 23'd0};
    else                               res = {s2_sign_q, rnd[30:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) bits_o <= res;
  end

endmodule

/* rtl/tmfp_back.sv */
// back end: pops records and scales delta records through three float lanes
// depends on tmfp_pkg and tmfp_fmul
module tmfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tmfp_pkg::rec_t q_rec_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tmfp_pkg::rec_t out_rec_o,
  output logic [31:0]    dx_bits_o,
  output logic [31:0]    dy_bits_o,
  output logic [31:0]    dz_bits_o
);

  logic           adv;
  logic           s1_v_q, s2_v_q, out_v_q;
  tmfp_pkg::rec_t s1_rec_q, s2_rec_q, out_rec_q;
  logic [31:0]    lx, ly, lz;
  logic           is_delta;

  // whole pipeline moves when the output slot is free or being taken
  assign adv     = !out_v_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= q_valid_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rec_q  <= q_rec_i;
      s2_rec_q  <= s1_rec_q;
      out_rec_q <= s2_rec_q;
    end
  end

  // three lanes in step with the record
  tmfp_fmul u_lane_x (.clk_i, .en_i(adv), .raw_i(q_rec_i.dx), .mult_i(q_rec_i.mult),
                      .bits_o(lx));
  tmfp_fmul u_lane_y (.clk_i, .en_i(adv), .raw_i(q_rec_i.dy), .mult_i(q_rec_i.mult),
                      .bits_o(ly));
  tmfp_fmul u_lane_z (.clk_i, .en_i(adv), .raw_i(q_rec_i.dz), .mult_i(q_rec_i.mult),
                      .bits_o(lz));

  assign is_delta    = (out_rec_q.kind == tmfp_pkg::KindDelta);
  assign out_valid_o = out_v_q;
  assign out_rec_o   = out_rec_q;
  assign dx_bits_o   = is_delta ? lx : 32'd0;
  assign dy_bits_o   = is_delta ? ly : 32'd0;
  assign dz_bits_o   = is_delta ? lz : 32'd0;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && s1_v_q == $past(s1_v_q)))
    else $error("pipeline moved during stall");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> s1_v_q)
    else $error("popped record lost");
  a_stage_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_v_q) |=> out_v_q)
    else $error("record dropped at output");
`endif

endmodule

/* rtl/tri_morph_file_parser.sv */
// morph file parser, one byte accepted per cycle while the queue has room for two records
// a record passes from the queue through the s1 and s2 registers to the output register
// throughput: one byte a cycle until the queue fills, as when out_ready_i stalls output
// reset: asynchronous, active low; clears the walk to the magic check and empties the queue
// depends on tmfp_pkg, tmfp_front, tmfp_queue, tmfp_back
module tri_morph_file_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  record_kind_o,
  output logic [7:0]  char_or_length_o,
  output logic [15:0] morph_vertices_o,
  output logic [15:0] vertex_number_o,
  output logic [31:0] delta_x_bits_o,
  output logic [31:0] delta_y_bits_o,
  output logic [31:0] delta_z_bits_o,
  output logic [1:0]  parse_status_o,
  output logic        run_end_o
);

  tmfp_pkg::push_t push;
  tmfp_pkg::rec_t  q_rec, o_rec;
  logic            room, q_valid, q_pop, acc;

  assign in_ready_o = room;
  assign acc        = in_valid_i && room;

  tmfp_front u_front (
    .clk_i, .rst_ni, .acc_i(acc), .byte_i(data_byte_i), .final_i(final_byte_i),
    .push_o(push)
  );

  tmfp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .room_o(room), .valid_o(q_valid), .rec_o(q_rec),
    .pop_i(q_pop)
  );

  tmfp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_rec_i(q_rec), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_rec_o(o_rec),
    .dx_bits_o(delta_x_bits_o), .dy_bits_o(delta_y_bits_o), .dz_bits_o(delta_z_bits_o)
  );

  assign record_kind_o    = o_rec.kind;
  assign char_or_length_o = o_rec.col;
  assign morph_vertices_o = o_rec.mv;
  assign vertex_number_o  = o_rec.vn;
  assign parse_status_o   = o_rec.st;
  assign run_end_o        = o_rec.run_end;

endmodule
